FILE: design/pts_pkg.sv
package pts_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int SLOT_W     = 4;
   localparam int PRIO_W     = 5;
   localparam int KEY_W      = 4;
   localparam int COUNT_W    = 5;
   localparam int DELAY_W    = 32;
   localparam int SLICE_W    = 16;
   localparam int LOCK_W     = 8;

   localparam logic [LOCK_W-1:0]  LOCK_MAX    = 8'd255;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

   typedef enum logic [2:0] {
      REQ_READY    = 3'd0,
      REQ_UNREADY  = 3'd1,
      REQ_DSTART   = 3'd2,
      REQ_DCANCEL  = 3'd3,
      REQ_TICK     = 3'd4,
      REQ_SCHEDULE = 3'd5,
      REQ_LOCK     = 3'd6,
      REQ_UNLOCK   = 3'd7
   } req_code_type;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_READY   = 3'd1,
      OP_UNREADY = 3'd2,
      OP_DSTART  = 3'd3,
      OP_DCANCEL = 3'd4,
      OP_TSTEP   = 3'd5,
      OP_SLICE   = 3'd6
   } op_type;

   // command broadcast from the sequencer to every cell
   typedef struct packed {
      op_type              op;
      logic                act;
      logic                move;
      logic                add_any;
      logic [SLOT_W-1:0]   slot;
      logic [PRIO_W-1:0]   prio;
      logic [DELAY_W-1:0]  ticks;
      logic [KEY_W-1:0]    ref_key;
      logic [KEY_W-1:0]    count;
      logic [KEY_W-1:0]    cur;
      logic [SLICE_W-1:0]  reload;
   } cmd_type;

   typedef struct packed {
      logic              queued;
      logic              delayed;
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  rank;
      logic              hit;
      logic              add;
      logic              slice_one;
   } status_type;

   // best candidate handed along the row of cells
   typedef struct packed {
      logic               found;
      logic [PRIO_W-1:0]  prio;
      logic [KEY_W-1:0]   key;
      logic [SLOT_W-1:0]  task_id;
   } scan_type;

endpackage

FILE: design/pts_req_if.sv
interface pts_req_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   req_type;
   logic [pts_pkg::SLOT_W-1:0]   task_slot;
   logic [pts_pkg::PRIO_W-1:0]   task_priority;
   logic [pts_pkg::DELAY_W-1:0]  delay_count;

   modport source (output valid, req_type, task_slot, task_priority, delay_count,
                   input ready);
   modport sink   (input valid, req_type, task_slot, task_priority, delay_count,
                   output ready);
endinterface

FILE: design/pts_rsp_if.sv
interface pts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pts_pkg::SLOT_W-1:0]   chosen_task;
   logic                         switch_now;
   logic                         none_ready;
   logic [pts_pkg::LOCK_W-1:0]   lock_depth;
   logic [pts_pkg::COUNT_W-1:0]  woken_count;

   modport source (output valid, chosen_task, switch_now, none_ready, lock_depth,
                   woken_count, input ready);
   modport sink   (input valid, chosen_task, switch_now, none_ready, lock_depth,
                   woken_count, output ready);
endinterface

FILE: design/pts_cell.sv
module pts_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pts_pkg::SLOT_W-1:0]  cell_index,
   input  pts_pkg::cmd_type            cmd,
   input  pts_pkg::scan_type           scan_in,
   output pts_pkg::scan_type           scan_out,
   output pts_pkg::status_type         status
);

   logic                          queued_ff, queued_in;
   logic                          delayed_ff, delayed_in;
   logic [pts_pkg::PRIO_W-1:0]    prio_ff, prio_in;
   logic [pts_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [pts_pkg::KEY_W-1:0]     rank_ff, rank_in;
   logic [pts_pkg::DELAY_W-1:0]   delay_ff, delay_in;
   logic [pts_pkg::SLICE_W-1:0]   slice_ff, slice_in;
   pts_pkg::scan_type             scan_ff, scan_in_w;

   logic mine, match, hit, add, own_better;

   assign mine  = (cell_index == cmd.slot);
   assign match = delayed_ff && (rank_ff == cmd.cur);
   assign hit   = match && (delay_ff == 32'd1);
   assign add   = hit && !queued_ff;

   assign status.queued    = queued_ff;
   assign status.delayed   = delayed_ff;
   assign status.key       = key_ff;
   assign status.rank      = rank_ff;
   assign status.hit       = hit;
   assign status.add       = add;
   assign status.slice_one = (slice_ff == 16'd1);

   always_comb begin
      queued_in  = queued_ff;
      delayed_in = delayed_ff;
      prio_in    = prio_ff;
      key_in     = key_ff;
      rank_in    = rank_ff;
      delay_in   = delay_ff;
      slice_in   = slice_ff;
      case (cmd.op)
         pts_pkg::OP_READY: begin
            if (cmd.act) begin
               if (mine) begin
                  queued_in = 1'b1;
                  prio_in   = cmd.prio;
                  key_in    = '0;
               end else if (queued_ff) begin
                  key_in = key_ff + 1'b1;
               end
            end
         end
         pts_pkg::OP_UNREADY: begin
            if (cmd.act) begin
               if (mine) begin
                  queued_in = 1'b0;
               end else if (queued_ff && key_ff > cmd.ref_key) begin
                  key_in = key_ff - 1'b1;
               end
            end
         end
         pts_pkg::OP_DSTART: begin
            if (mine) begin
               delay_in = cmd.ticks;
               if (cmd.act) begin
                  delayed_in = 1'b1;
                  rank_in    = cmd.count;
               end
            end
         end
         pts_pkg::OP_DCANCEL: begin
            if (cmd.act) begin
               if (mine) begin
                  delayed_in = 1'b0;
               end else if (delayed_ff && rank_ff > cmd.ref_key) begin
                  rank_in = rank_ff - 1'b1;
               end
            end
         end
         pts_pkg::OP_TSTEP: begin
            if (match) begin
               delay_in = delay_ff - 1'b1;
            end
            if (hit) begin
               delayed_in = 1'b0;
            end
            if (add) begin
               queued_in = 1'b1;
               key_in    = '0;
            end else if (cmd.add_any && queued_ff) begin
               key_in = key_ff + 1'b1;
            end
            // a wake closes the gap behind it in the delay list
            if (cmd.act && delayed_ff && rank_ff > cmd.cur) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         pts_pkg::OP_SLICE: begin
            if (mine) begin
               slice_in = cmd.act ? cmd.reload : slice_ff - 1'b1;
               if (cmd.move) begin
                  key_in = cmd.count;
               end
            end else if (cmd.move && queued_ff && key_ff > cmd.ref_key) begin
               key_in = key_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      own_better = queued_ff && (!scan_in.found || prio_ff < scan_in.prio ||
                   (prio_ff == scan_in.prio && key_ff < scan_in.key));
      if (own_better) begin
         scan_in_w.found   = 1'b1;
         scan_in_w.prio    = prio_ff;
         scan_in_w.key     = key_ff;
         scan_in_w.task_id = cell_index;
      end else begin
         scan_in_w = scan_in;
      end
   end

   assign scan_out = scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff  <= 1'b0;
         delayed_ff <= 1'b0;
         slice_ff   <= pts_pkg::SLICE_RESET;
      end else begin
         queued_ff  <= queued_in;
         delayed_ff <= delayed_in;
         slice_ff   <= slice_in;
      end
      prio_ff  <= prio_in;
      key_ff   <= key_in;
      rank_ff  <= rank_in;
      delay_ff <= delay_in;
      scan_ff  <= scan_in_w;
   end

endmodule

FILE: design/priority_task_scheduler.sv
// priority task scheduler: ready queues per priority, delay list, time slices
// and a scheduler lock, held in a row of sixteen task cells.
// requests arrive on req_bus (valid/ready), one response per request leaves
// on rsp_bus. one request is worked at a time; req_bus.ready is high while
// the sequencer is idle, also while an earlier response still waits.
// a request is worked in steps: it is executed, the best candidate travels
// down the row of cells and the response is finished; a tick adds 16
// delay-list steps and 1 slice step between the execution and the scan.
// no new request is taken before the response is loaded, since ready
// returns in the cycle after the response is loaded.
// a stalled response holds in the output register; a following request is
// then worked but not finished until the response is taken.
// slice_reload is written through the csr_ port at byte address 0.
// reset clears the queues, the delay list, the lock count and the running
// task, sets every slice to 10 and the reload value to 10.
module priority_task_scheduler (
   input  logic         clock,
   input  logic         reset,
   pts_req_if.sink      req_bus,
   pts_rsp_if.source    rsp_bus,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_TICK  = 6'b000100,
      ST_SLICE = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   pts_pkg::req_code_type            type_ff, type_in;
   logic [pts_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [pts_pkg::PRIO_W-1:0]       prio_ff, prio_in;
   logic [pts_pkg::DELAY_W-1:0]      ticks_ff, ticks_in;
   logic [pts_pkg::COUNT_W-1:0]      qcount_ff, qcount_in;
   logic [pts_pkg::COUNT_W-1:0]      dcount_ff, dcount_in;
   logic [pts_pkg::KEY_W-1:0]        cur_ff, cur_in;
   logic [pts_pkg::KEY_W-1:0]        step_ff, step_in;
   logic [pts_pkg::COUNT_W-1:0]      woken_ff, woken_in;
   logic                             sched_ff, sched_in;
   logic [pts_pkg::LOCK_W-1:0]       lock_ff, lock_in;
   logic [pts_pkg::SLOT_W-1:0]       running_ff, running_in;
   logic [pts_pkg::SLICE_W-1:0]      reload_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pts_pkg::SLOT_W-1:0]       chosen_ff, chosen_in;
   logic                             switch_ff, switch_in;
   logic                             none_ff, none_in;
   logic [pts_pkg::LOCK_W-1:0]       depth_ff, depth_in;
   logic [pts_pkg::COUNT_W-1:0]      wcount_ff, wcount_in;

   pts_pkg::cmd_type                 cmd;
   pts_pkg::status_type              status [pts_pkg::TASK_SLOTS];
   pts_pkg::scan_type                chain  [pts_pkg::TASK_SLOTS+1];
   pts_pkg::scan_type                best;
   logic [pts_pkg::TASK_SLOTS-1:0]   hits, adds;
   logic                             woken_any, add_any, expire, move, load_rsp;

   assign chain[0] = '0;

   for (genvar i = 0; i < pts_pkg::TASK_SLOTS; i++) begin : g_cell
      pts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (pts_pkg::SLOT_W'(i)),
         .cmd        (cmd),
         .scan_in    (chain[i]),
         .scan_out   (chain[i+1]),
         .status     (status[i])
      );
      assign hits[i] = status[i].hit;
      assign adds[i] = status[i].add;
   end

   assign best      = chain[pts_pkg::TASK_SLOTS];
   assign woken_any = |hits;
   assign add_any   = |adds;
   assign expire    = status[running_ff].slice_one;
   assign move      = expire && status[running_ff].queued;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.chosen_task = chosen_ff;
   assign rsp_bus.switch_now  = switch_ff;
   assign rsp_bus.none_ready  = none_ff;
   assign rsp_bus.lock_depth  = depth_ff;
   assign rsp_bus.woken_count = wcount_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {16'd0, reload_ff};

   // command to the cells
   always_comb begin
      cmd         = '0;
      cmd.op      = pts_pkg::OP_NONE;
      cmd.slot    = slot_ff;
      cmd.prio    = prio_ff;
      cmd.ticks   = ticks_ff;
      cmd.cur     = cur_ff;
      cmd.reload  = reload_ff;
      cmd.add_any = add_any;
      unique case (state_ff)
         ST_EXEC: begin
            case (type_ff)
               pts_pkg::REQ_READY: begin
                  cmd.op  = pts_pkg::OP_READY;
                  cmd.act = !status[slot_ff].queued;
               end
               pts_pkg::REQ_UNREADY: begin
                  cmd.op      = pts_pkg::OP_UNREADY;
                  cmd.act     = status[slot_ff].queued;
                  cmd.ref_key = status[slot_ff].key;
               end
               pts_pkg::REQ_DSTART: begin
                  cmd.op    = pts_pkg::OP_DSTART;
                  cmd.act   = !status[slot_ff].delayed;
                  cmd.count = dcount_ff[pts_pkg::KEY_W-1:0];
               end
               pts_pkg::REQ_DCANCEL: begin
                  cmd.op      = pts_pkg::OP_DCANCEL;
                  cmd.act     = status[slot_ff].delayed;
                  cmd.ref_key = status[slot_ff].rank;
               end
               default: begin
               end
            endcase
         end
         ST_TICK: begin
            cmd.op  = pts_pkg::OP_TSTEP;
            cmd.act = woken_any;
         end
         ST_SLICE: begin
            cmd.op      = pts_pkg::OP_SLICE;
            cmd.slot    = running_ff;
            cmd.act     = expire;
            cmd.move    = move;
            cmd.ref_key = status[running_ff].key;
            cmd.count   = pts_pkg::KEY_W'(qcount_ff - 1'b1);
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      slot_in      = slot_ff;
      prio_in      = prio_ff;
      ticks_in     = ticks_ff;
      qcount_in    = qcount_ff;
      dcount_in    = dcount_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      woken_in     = woken_ff;
      sched_in     = sched_ff;
      lock_in      = lock_ff;
      running_in   = running_ff;
      chosen_in    = chosen_ff;
      switch_in    = switch_ff;
      none_in      = none_ff;
      depth_in     = depth_ff;
      wcount_in    = wcount_ff;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               type_in  = pts_pkg::req_code_type'(req_bus.req_type);
               slot_in  = req_bus.task_slot;
               prio_in  = req_bus.task_priority;
               ticks_in = req_bus.delay_count;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            sched_in = 1'b0;
            woken_in = '0;
            cur_in   = '0;
            step_in  = '0;
            state_in = ST_SCAN;
            unique case (type_ff)
               pts_pkg::REQ_READY: begin
                  if (!status[slot_ff].queued) qcount_in = qcount_ff + 1'b1;
               end
               pts_pkg::REQ_UNREADY: begin
                  if (status[slot_ff].queued) qcount_in = qcount_ff - 1'b1;
               end
               pts_pkg::REQ_DSTART: begin
                  if (!status[slot_ff].delayed) dcount_in = dcount_ff + 1'b1;
               end
               pts_pkg::REQ_DCANCEL: begin
                  if (status[slot_ff].delayed) dcount_in = dcount_ff - 1'b1;
               end
               pts_pkg::REQ_TICK: begin
                  sched_in = 1'b1;
                  state_in = ST_TICK;
               end
               pts_pkg::REQ_SCHEDULE: begin
                  sched_in = 1'b1;
               end
               pts_pkg::REQ_LOCK: begin
                  if (lock_ff != pts_pkg::LOCK_MAX) lock_in = lock_ff + 1'b1;
               end
               pts_pkg::REQ_UNLOCK: begin
                  if (lock_ff != '0) begin
                     lock_in  = lock_ff - 1'b1;
                     sched_in = (lock_ff == 8'd1);
                  end
               end
            endcase
         end
         ST_TICK: begin
            // one delay-list entry per step; a woken entry leaves its place
            if (woken_any) begin
               woken_in  = woken_ff + 1'b1;
               dcount_in = dcount_ff - 1'b1;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
            if (add_any) qcount_in = qcount_ff + 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == pts_pkg::KEY_W'(pts_pkg::TASK_SLOTS - 1)) state_in = ST_SLICE;
         end
         ST_SLICE: begin
            step_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == pts_pkg::KEY_W'(pts_pkg::TASK_SLOTS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               switch_in    = sched_ff && (lock_ff == '0) && best.found &&
                              (best.task_id != running_ff);
               if (switch_in) running_in = best.task_id;
               chosen_in = best.found ? best.task_id : '0;
               none_in   = !best.found;
               depth_in  = lock_ff;
               wcount_in = woken_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qcount_ff    <= '0;
         dcount_ff    <= '0;
         lock_ff      <= '0;
         running_ff   <= '0;
         reload_ff    <= pts_pkg::SLICE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qcount_ff    <= qcount_in;
         dcount_ff    <= dcount_in;
         lock_ff      <= lock_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
            reload_ff <= csr_pwdata[15:0];
         end
      end
      type_ff  <= type_in;
      slot_ff  <= slot_in;
      prio_ff  <= prio_in;
      ticks_ff <= ticks_in;
      cur_ff   <= cur_in;
      step_ff  <= step_in;
      woken_ff <= woken_in;
      sched_ff <= sched_in;
      if (load_rsp) begin
         chosen_ff <= chosen_in;
         switch_ff <= switch_in;
         none_ff   <= none_in;
         depth_ff  <= depth_in;
         wcount_ff <= wcount_in;
      end
   end

endmodule

FILE: tb/sv/priority_task_scheduler_tb.sv
`timescale 1ns / 100ps

module priority_task_scheduler_tb;

   typedef struct {
      pts_pkg::req_code_type  kind;
      logic [3:0]             slot;
      logic [4:0]             prio;
      logic [31:0]            ticks;
   } sched_req_type;

   typedef struct {
      logic [3:0]  chosen;
      logic        sw;
      logic        none;
      logic [7:0]  lock;
      logic [4:0]  woken;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pts_req_if req_bus ();
   pts_rsp_if rsp_bus ();

   priority_task_scheduler u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scheduler mirror state
   logic [15:0] slice_reload_m;
   logic [31:0] ready_bits;
   logic [3:0]  q_head [32];
   logic [3:0]  q_tail [32];
   logic [3:0]  q_next [16];
   logic [4:0]  task_prio [16];
   logic [31:0] wait_left [16];
   logic [3:0]  d_next [16];
   logic [3:0]  d_head, d_tail;
   logic        d_any;
   logic [15:0] slice_cnt [16];
   logic [3:0]  running;
   logic [7:0]  nesting;
   logic        queued [16];
   logic        delayed [16];

   sched_req_type pending_reqs[$];
   sched_rsp_type expected_rsps[$];
   sched_req_type cur_req;
   logic       req_fire = 1'b0;
   bit         prio_known [16];
   int         fails = 0;
   int         cyc = 0;
   int         hold_left = 0;
   bit         calm;

   function automatic void q_insert(logic [3:0] t, bit at_head);
      logic [4:0] p;
      p = task_prio[t];
      if (ready_bits[p]) begin
         if (at_head) begin
            q_next[t] = q_head[p];
            q_head[p] = t;
         end else begin
            q_next[q_tail[p]] = t;
            q_tail[p] = t;
         end
      end else begin
         q_head[p] = t;
         q_tail[p] = t;
         ready_bits[p] = 1'b1;
      end
      queued[t] = 1'b1;
   endfunction

   function automatic void q_drop(logic [3:0] t);
      logic [4:0] p;
      logic [3:0] prev;
      p = task_prio[t];
      if (!queued[t]) return;
      queued[t] = 1'b0;
      if (q_head[p] == t) begin
         if (q_tail[p] == t) ready_bits[p] = 1'b0;
         else q_head[p] = q_next[t];
         return;
      end
      prev = q_head[p];
      for (int i = 0; i < 16; i++) begin
         if (q_next[prev] == t) begin
            q_next[prev] = q_next[t];
            if (q_tail[p] == t) q_tail[p] = prev;
            return;
         end
         prev = q_next[prev];
      end
   endfunction

   function automatic void d_drop(logic [3:0] t);
      logic [3:0] prev;
      if (!delayed[t]) return;
      delayed[t] = 1'b0;
      if (d_head == t) begin
         if (d_tail == t) d_any = 1'b0;
         else d_head = d_next[t];
         return;
      end
      prev = d_head;
      for (int i = 0; i < 16; i++) begin
         if (d_next[prev] == t) begin
            d_next[prev] = d_next[t];
            if (d_tail == t) d_tail = prev;
            return;
         end
         prev = d_next[prev];
      end
   endfunction

   function automatic bit top_task(output logic [3:0] t);
      t = '0;
      for (int p = 0; p < 32; p++)
         if (ready_bits[p]) begin
            t = q_head[p];
            return 1'b1;
         end
      return 1'b0;
   endfunction

   function automatic logic try_switch();
      logic [3:0] t;
      if (nesting != 0 || !top_task(t)) return 1'b0;
      if (t != running) begin
         running = t;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [4:0] tick_step();
      logic [4:0] woken;
      logic [3:0] c, n;
      bit         last;
      woken = '0;
      if (d_any) begin
         c = d_head;
         for (int i = 0; i < 16; i++) begin
            n = d_next[c];
            last = (c == d_tail);
            wait_left[c] = wait_left[c] - 32'd1;
            if (wait_left[c] == 0) begin
               d_drop(c);
               if (!queued[c]) q_insert(c, 1'b1);
               woken++;
            end
            if (last) break;
            c = n;
         end
      end
      c = running;
      slice_cnt[c] = slice_cnt[c] - 16'd1;
      if (slice_cnt[c] == 0) begin
         if (queued[c]) begin
            q_drop(c);
            q_insert(c, 1'b0);
         end
         slice_cnt[c] = slice_reload_m;
      end
      return woken;
   endfunction

   function automatic sched_rsp_type predict_rsp(sched_req_type r);
      sched_rsp_type o;
      logic [3:0] t;
      o.sw = 1'b0;
      o.woken = '0;
      case (r.kind)
         pts_pkg::REQ_READY: begin
            if (!queued[r.slot]) begin
               task_prio[r.slot] = r.prio;
               q_insert(r.slot, 1'b1);
            end
         end
         pts_pkg::REQ_UNREADY: q_drop(r.slot);
         pts_pkg::REQ_DSTART: begin
            wait_left[r.slot] = r.ticks;
            if (!delayed[r.slot]) begin
               if (d_any) d_next[d_tail] = r.slot;
               else begin
                  d_head = r.slot;
                  d_any = 1'b1;
               end
               d_tail = r.slot;
               delayed[r.slot] = 1'b1;
            end
         end
         pts_pkg::REQ_DCANCEL: d_drop(r.slot);
         pts_pkg::REQ_TICK: begin
            o.woken = tick_step();
            o.sw = try_switch();
         end
         pts_pkg::REQ_SCHEDULE: o.sw = try_switch();
         pts_pkg::REQ_LOCK: if (nesting != pts_pkg::LOCK_MAX) nesting++;
         default: begin
            if (nesting != 0) begin
               nesting--;
               if (nesting == 0) o.sw = try_switch();
            end
         end
      endcase
      o.none = !top_task(t);
      o.chosen = t;
      o.lock = nesting;
      return o;
   endfunction

   function automatic void mirror_reset();
      slice_reload_m = pts_pkg::SLICE_RESET;
      ready_bits = '0;
      for (int i = 0; i < 32; i++) begin
         q_head[i] = '0;
         q_tail[i] = '0;
      end
      for (int i = 0; i < 16; i++) begin
         q_next[i] = '0;
         task_prio[i] = '0;
         wait_left[i] = '0;
         d_next[i] = '0;
         slice_cnt[i] = pts_pkg::SLICE_RESET;
         queued[i] = 1'b0;
         delayed[i] = 1'b0;
      end
      d_head = '0;
      d_tail = '0;
      d_any = 1'b0;
      running = '0;
      nesting = '0;
   endfunction

   function automatic sched_req_type make_req(pts_pkg::req_code_type k, int s, int p,
                                              logic [31:0] n);
      sched_req_type r;
      r.kind = k;
      r.slot = 4'(s);
      r.prio = 5'(p);
      r.ticks = n;
      if (k == pts_pkg::REQ_READY) prio_known[s] = 1'b1;
      return r;
   endfunction

   function automatic sched_req_type random_req();
      int w, s, p;
      logic [31:0] n;
      w = $urandom % 100;
      s = $urandom_range(0, 15);
      p = ($urandom % 2) ? $urandom_range(0, 3) : $urandom_range(0, 31);
      n = $urandom;
      if (w < 22) return make_req(pts_pkg::REQ_READY, s, p, n);
      if (w < 32) return make_req(pts_pkg::REQ_UNREADY, s, p, n);
      if (w < 47) begin
         // never delay a task whose priority was never set
         if (!prio_known[s]) return make_req(pts_pkg::REQ_READY, s, p, n);
         w = $urandom % 100;
         if (w < 80) n = $urandom_range(1, 6);
         else if (w < 95) n = $urandom;
         else n = '0;
         return make_req(pts_pkg::REQ_DSTART, s, p, n);
      end
      if (w < 55) return make_req(pts_pkg::REQ_DCANCEL, s, p, n);
      if (w < 75) return make_req(pts_pkg::REQ_TICK, s, p, n);
      if (w < 85) return make_req(pts_pkg::REQ_SCHEDULE, s, p, n);
      if (w < 93) return make_req(pts_pkg::REQ_LOCK, s, p, n);
      return make_req(pts_pkg::REQ_UNLOCK, s, p, n);
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
         @(posedge clock);
      // a tick may still be finishing internally
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reload(logic [15:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {16'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      slice_reload_m = v;
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_fire)) begin
         if (pending_reqs.size() != 0 && (calm || ($urandom % 100) >= 37)) begin
            cur_req = pending_reqs.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.req_type <= cur_req.kind;
            req_bus.task_slot <= cur_req.slot;
            req_bus.task_priority <= cur_req.prio;
            req_bus.delay_count <= cur_req.ticks;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_fire = req_bus.valid && req_bus.ready;
      if (req_fire) expected_rsps.push_back(predict_rsp(cur_req));
   end

   // response side: random stalls plus one long hold-off
   always @(negedge clock) begin
      cyc <= cyc + 1;
      if (cyc == 4000) hold_left = 400;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom % 100) >= 37;
      end
   end

   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response chosen=%0d", $time, rsp_bus.chosen_task);
            fails++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_bus.chosen_task !== e.chosen) begin
               $display("%0t: chosen_task exp %0d got %0d", $time, e.chosen,
                        rsp_bus.chosen_task);
               fails++;
            end
            if (rsp_bus.switch_now !== e.sw) begin
               $display("%0t: switch_now exp %0d got %0d", $time, e.sw, rsp_bus.switch_now);
               fails++;
            end
            if (rsp_bus.none_ready !== e.none) begin
               $display("%0t: none_ready exp %0d got %0d", $time, e.none, rsp_bus.none_ready);
               fails++;
            end
            if (rsp_bus.lock_depth !== e.lock) begin
               $display("%0t: lock_depth exp %0d got %0d", $time, e.lock, rsp_bus.lock_depth);
               fails++;
            end
            if (rsp_bus.woken_count !== e.woken) begin
               $display("%0t: woken_count exp %0d got %0d", $time, e.woken,
                        rsp_bus.woken_count);
               fails++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [15:0] reloads [4];
      reloads = '{16'd1, 16'd65535, 16'd4, 16'd10};
      req_bus.valid = 1'b0;
      req_bus.req_type = pts_pkg::REQ_READY;
      req_bus.task_slot = '0;
      req_bus.task_priority = '0;
      req_bus.delay_count = '0;
      rsp_bus.ready = 1'b0;
      calm = 1'b0;
      mirror_reset();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes and corner cases at the reset slice length
      pending_reqs.push_back(make_req(pts_pkg::REQ_SCHEDULE, 0, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_UNLOCK, 0, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_TICK, 0, 0, 32'hffff_ffff));
      pending_reqs.push_back(make_req(pts_pkg::REQ_UNREADY, 3, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_DCANCEL, 3, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_READY, 15, 31, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_READY, 0, 0, 32'hffff_ffff));
      pending_reqs.push_back(make_req(pts_pkg::REQ_READY, 5, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_READY, 5, 7, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_LOCK, 0, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_SCHEDULE, 0, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_UNLOCK, 0, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_DSTART, 15, 0, 32'd2));
      pending_reqs.push_back(make_req(pts_pkg::REQ_DSTART, 0, 0, 32'd0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_DSTART, 15, 0, 32'd1));
      pending_reqs.push_back(make_req(pts_pkg::REQ_TICK, 0, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_UNREADY, 5, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_DSTART, 5, 0, 32'd1));
      pending_reqs.push_back(make_req(pts_pkg::REQ_TICK, 0, 0, 0));
      pending_reqs.push_back(make_req(pts_pkg::REQ_DCANCEL, 0, 0, 0));
      for (int i = 0; i < 4; i++)
         pending_reqs.push_back(make_req(pts_pkg::REQ_TICK, 0, 0, 0));
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         write_reload(reloads[ph]);
         if (ph == 1) begin
            // saturate the lock count, then unwind it
            for (int i = 0; i < 257; i++)
               pending_reqs.push_back(make_req(pts_pkg::REQ_LOCK, 0, 0, 0));
            for (int i = 0; i < 257; i++)
               pending_reqs.push_back(make_req(pts_pkg::REQ_UNLOCK, 0, 0, 0));
         end
         for (int i = 0; i < 340; i++) pending_reqs.push_back(random_req());
         calm = (ph == 2);
         wait_idle();
         calm = 1'b0;
      end

      repeat (60) @(posedge clock);
      if (fails == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
